/* sv/btp_pkg.sv */
// Shared types, constants and divisor tables for the binomial tail probability block.
`default_nettype none

package btp_pkg;

  // Request and response payloads.
  typedef struct packed {
    logic       func;
    logic [5:0] threshold;
  } req_t;

  typedef struct packed {
    logic [16:0] probability;
    logic        beyond_trials;
  } rsp_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SUCCESS_PROB = 2'd0,
    CFG_TRIAL_COUNT  = 2'd1
  } cfg_index_t;

  // Request modes.
  localparam logic FUNC_AT_MOST  = 1'b0;
  localparam logic FUNC_AT_LEAST = 1'b1;

  // Power format: 32 fraction bits plus one integer bit, 2^32 is 1.0.
  localparam int unsigned POW_W = 33;
  localparam logic [POW_W-1:0] ONE_POW = {1'b1, 32'd0};
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // C(32,16) is the largest coefficient and fits in 30 bits.
  localparam int unsigned COEF_W = 30;
  // Each term is at most 1.0 in power format; the running sum stays below 2^33.
  localparam int unsigned SUM_W = 34;
  // Coefficient times (n-k) before the exact division.
  localparam int unsigned CPROD_W = 35;

  localparam int unsigned DIV_ENTRIES = 32;

  typedef logic [31:0] inv_tbl_t [DIV_ENTRIES];
  typedef logic [2:0]  shf_tbl_t [DIV_ENTRIES];

  // Inverse of an odd number modulo 2^32 by Newton steps (elaboration only).
  function automatic logic [31:0] odd_inv(input logic [31:0] o);
    logic [31:0] x;
    x = o;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - o * x);
    end
    return x;
  endfunction

  // Entry k serves divisor k+1: shift out its factors of two, then multiply by
  // the inverse of its odd part. The division is always exact.
  function automatic inv_tbl_t build_inv_tbl();
    inv_tbl_t    tbl;
    logic [31:0] o;
    for (int k = 0; k < DIV_ENTRIES; k++) begin
      o = 32'(k + 1);
      for (int j = 0; j < 5; j++) begin
        if (!o[0]) begin
          o = o >> 1;
        end
      end
      tbl[k] = odd_inv(o);
    end
    return tbl;
  endfunction

  function automatic shf_tbl_t build_shf_tbl();
    shf_tbl_t    tbl;
    logic [31:0] o;
    logic [2:0]  s;
    for (int k = 0; k < DIV_ENTRIES; k++) begin
      o = 32'(k + 1);
      s = 3'd0;
      for (int j = 0; j < 5; j++) begin
        if (!o[0]) begin
          o = o >> 1;
          s = s + 3'd1;
        end
      end
      tbl[k] = s;
    end
    return tbl;
  endfunction

  localparam inv_tbl_t INV_TBL = build_inv_tbl();
  localparam shf_tbl_t SHF_TBL = build_shf_tbl();

endpackage

`default_nettype wire

/* sv/binomial_tail_probability.sv */
// Binomial tail probability engine: P(X<=t) or P(X>=t) on one shared multiplier.
// A threshold above n is answered straight from idle; otherwise the block builds the
// (1-p) power table, works through the terms one by one and then rounds and finishes,
// using the single 32x32 multiplier that the working states share. Busy drops as the
// result is strobed, and no new request is accepted while busy.
// Reset (synchronous, rst high) returns to idle with p = 0 and n = 0; the result
// strobe done is one cycle wide and cannot be held off by the receiver.
`default_nettype none

module binomial_tail_probability
  import btp_pkg::*;
#(
  parameter int MAX_TRIALS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        start,
  input  wire req_t        req,
  output logic             busy,
  // response channel
  output logic             done,
  output rsp_t             rsp,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int DEPTH = MAX_TRIALS + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // One-hot sequencer. Each step uses the multiplier once at most.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,  // wait for a request
    S_QPOW  = 9'b000000010,  // build (1-p)^j into the table
    S_TREAD = 9'b000000100,  // fetch (1-p)^(n-k)
    S_TPQ   = 9'b000001000,  // p^k * (1-p)^(n-k)
    S_TTERM = 9'b000010000,  // times C(n,k)
    S_TPP   = 9'b000100000,  // accumulate, advance p^k
    S_TC1   = 9'b001000000,  // C(n,k) * (n-k)
    S_TC2   = 9'b010000000,  // exact divide by k+1
    S_FIN   = 9'b100000000   // round, saturate, strobe
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [16:0] success_prob;
  logic [5:0]  trial_count;

  // Per-request working registers.
  logic [5:0]       n, lo, hi, k;
  logic [POW_W-1:0] p32, q32, qv, pp, t, qrd;
  logic [COEF_W-1:0] coef;
  logic [SUM_W-1:0]  term, sum;
  logic [CPROD_W-1:0] cprod;

  // (1-p) power table.
  logic [POW_W-1:0] qmem [DEPTH];
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [POW_W-1:0] mem_wdata;

  // Shared multiplier and its operand selection.
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [POW_W-1:0] pa, pb, pm;
  logic [CPROD_W-1:0] cshift;

  // Request decode at accept time.
  logic             accept;
  logic [16:0]      prob_eff;
  logic [5:0]       n_eff;
  logic [POW_W-1:0] p32_in;
  logic             beyond;
  logic [SUM_W-1:0] rounded;
  logic [17:0]      res_q16;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // Clamp p to 1.0 and n to the trial limit.
  assign prob_eff = (success_prob > ONE_Q16) ? ONE_Q16 : success_prob;
  assign n_eff    = (trial_count > 6'(MAX_TRIALS)) ? 6'(MAX_TRIALS) : trial_count;
  assign p32_in   = {prob_eff, 16'd0};
  assign beyond   = (req.threshold > n_eff);

  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign cshift = cprod >> SHF_TBL[k[4:0]];

  // Truncating power multiply; an operand of exactly 1.0 passes the other through.
  always_comb begin
    if (pa[POW_W-1]) begin
      pm = pb;
    end else if (pb[POW_W-1]) begin
      pm = pa;
    end else begin
      pm = {1'b0, mul_p[63:32]};
    end
  end

  // Operand steering for the shared multiplier.
  always_comb begin
    pa    = '0;
    pb    = '0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_QPOW: begin
        pa    = qv;
        pb    = q32;
        mul_a = qv[31:0];
        mul_b = q32[31:0];
      end
      S_TPQ: begin
        pa    = pp;
        pb    = qrd;
        mul_a = pp[31:0];
        mul_b = qrd[31:0];
      end
      S_TTERM: begin
        mul_a = 32'(coef);
        mul_b = t[31:0];
      end
      S_TPP: begin
        pa    = pp;
        pb    = p32;
        mul_a = pp[31:0];
        mul_b = p32[31:0];
      end
      S_TC1: begin
        mul_a = 32'(coef);
        mul_b = 32'(n - k);
      end
      S_TC2: begin
        mul_a = cshift[31:0];
        mul_b = INV_TBL[k[4:0]];
      end
      default: begin
      end
    endcase
  end

  // Table write and read ports.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k[AW-1:0];
    mem_wdata = pm;
    mem_re    = (state == S_TREAD);
    mem_raddr = 6'(n - k) > 6'(MAX_TRIALS) ? '0 : AW'(n - k);
    if (state == S_IDLE) begin
      // seed (1-p)^0 = 1.0 as the request comes in
      mem_we    = accept;
      mem_waddr = '0;
      mem_wdata = ONE_POW;
    end else if (state == S_QPOW) begin
      mem_we = (k <= n);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      qrd <= qmem[mem_raddr];
    end
  end

  // Sequencer transitions.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && !beyond) state_next = S_QPOW;
      S_QPOW:  if (k > n) state_next = S_TREAD;
      S_TREAD: state_next = S_TPQ;
      S_TPQ:   state_next = S_TTERM;
      S_TTERM: state_next = S_TPP;
      S_TPP:   state_next = (k == n) ? S_FIN : S_TC1;
      S_TC1:   state_next = S_TC2;
      S_TC2:   state_next = S_TREAD;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Round half up to Q1.16 and saturate at 1.0.
  assign rounded = sum + SUM_W'(32768);
  assign res_q16 = rounded[SUM_W-1:16];

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      success_prob <= '0;
      trial_count  <= '0;
    end else begin
      state <= state_next;
      done  <= (accept && beyond) || (state == S_FIN);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SUCCESS_PROB) begin
          success_prob <= cfg_data;
        end else if (cfg_index == CFG_TRIAL_COUNT) begin
          trial_count <= cfg_data[5:0];
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          // capture the request and the clamped operands
          n    <= n_eff;
          p32  <= p32_in;
          q32  <= ONE_POW - p32_in;
          lo   <= (req.func == FUNC_AT_MOST) ? 6'd0 : req.threshold;
          hi   <= (req.func == FUNC_AT_MOST) ? req.threshold : n_eff;
          qv   <= ONE_POW;
          k    <= 6'd1;
          if (beyond) begin
            // threshold past n: the whole mass is at or below it
            rsp.probability   <= (req.func == FUNC_AT_MOST) ? ONE_Q16 : 17'd0;
            rsp.beyond_trials <= 1'b1;
          end
        end
      end
      S_QPOW: begin
        if (k > n) begin
          k    <= 6'd0;
          pp   <= ONE_POW;
          coef <= COEF_W'(1);
          sum  <= '0;
        end else begin
          qv <= pm;
          k  <= k + 6'd1;
        end
      end
      S_TPQ: begin
        t <= pm;
      end
      S_TTERM: begin
        // a power of exactly 1.0 scales the coefficient by 2^32
        term <= t[POW_W-1] ? SUM_W'({coef, 32'd0}) : SUM_W'(mul_p);
      end
      S_TPP: begin
        if (k >= lo && k <= hi) begin
          sum <= sum + term;
        end
        pp <= pm;
      end
      S_TC1: begin
        cprod <= mul_p[CPROD_W-1:0];
      end
      S_TC2: begin
        coef <= mul_p[COEF_W-1:0];
        k    <= k + 6'd1;
      end
      S_FIN: begin
        rsp.probability   <= (res_q16 > 18'(ONE_Q16)) ? ONE_Q16 : res_q16[16:0];
        rsp.beyond_trials <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* tb/btp_tail_checker.sv */
// Checker for the binomial tail block: shadows the registers, predicts each response and compares.
`timescale 1ns / 100ps

module btp_tail_checker
  import btp_pkg::*;
#(
  parameter int MAX_TRIALS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  input  logic        busy,
  input  logic        done,
  input  rsp_t        rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          compared_count
);

  localparam logic [63:0] UNIT = 64'(ONE_POW);

  logic [16:0] shadow_prob;
  logic [5:0]  shadow_trials;
  rsp_t        expected_rsp_q[$];
  int          fails;
  int          compared;

  // Truncating multiply in the 33-bit power format; 1.0 passes the other side through.
  function automatic logic [63:0] pow_product(input logic [63:0] a, input logic [63:0] b);
    if (a >= UNIT) begin
      return b;
    end
    if (b >= UNIT) begin
      return a;
    end
    return (a * b) >> 32;
  endfunction

  function automatic rsp_t tail_prob_predict(input req_t r);
    logic [63:0] p_pow [MAX_TRIALS+1];
    logic [63:0] q_pow [MAX_TRIALS+1];
    logic [63:0] prob;
    logic [63:0] p32;
    logic [63:0] q32;
    logic [63:0] coef;
    logic [63:0] total;
    logic [63:0] rounded;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    rsp_t        o;
    prob = 64'(shadow_prob);
    if (prob > 64'(ONE_Q16)) begin
      prob = 64'(ONE_Q16);
    end
    n = (shadow_trials > MAX_TRIALS) ? MAX_TRIALS : shadow_trials;
    o.beyond_trials = 1'b0;
    if (r.threshold > n) begin
      o.probability   = (r.func == FUNC_AT_MOST) ? ONE_Q16 : '0;
      o.beyond_trials = 1'b1;
      return o;
    end
    p32 = prob << 16;
    q32 = UNIT - p32;
    p_pow[0] = UNIT;
    q_pow[0] = UNIT;
    for (int unsigned k = 1; k <= n; k++) begin
      p_pow[k] = pow_product(p_pow[k-1], p32);
      q_pow[k] = pow_product(q_pow[k-1], q32);
    end
    if (r.func == FUNC_AT_MOST) begin
      lo = 0;
      hi = r.threshold;
    end else begin
      lo = r.threshold;
      hi = n;
    end
    total = '0;
    coef  = 64'd1;
    for (int unsigned k = 0; k <= n; k++) begin
      if (k >= lo && k <= hi) begin
        total += coef * pow_product(p_pow[k], q_pow[n-k]);
      end
      coef = coef * 64'(n - k) / 64'(k + 1);
    end
    rounded = (total + 64'd32768) >> 16;
    if (rounded > 64'(ONE_Q16)) begin
      rounded = 64'(ONE_Q16);
    end
    o.probability = rounded[16:0];
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      shadow_prob   = '0;
      shadow_trials = '0;
      expected_rsp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SUCCESS_PROB: shadow_prob = cfg_data;
          CFG_TRIAL_COUNT: shadow_trials = cfg_data[5:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response: probability %0d, beyond_trials %0d",
                 rsp.probability, rsp.beyond_trials);
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.probability !== want.probability) begin
            $error("probability: expected %0d, actual %0d", want.probability, rsp.probability);
            fails++;
          end
          if (rsp.beyond_trials !== want.beyond_trials) begin
            $error("beyond_trials: expected %0d, actual %0d",
                   want.beyond_trials, rsp.beyond_trials);
            fails++;
          end
          compared++;
        end
      end
      if (start && !busy) begin
        expected_rsp_q.push_back(tail_prob_predict(req));
      end
    end
    pending        <= expected_rsp_q.size();
    fail_count     <= fails;
    compared_count <= compared;
  end

endmodule

/* tb/binomial_tail_probability_tb.sv */
// Testbench top for the binomial tail block: register settings, request stimulus and verdict.
`timescale 1ns / 100ps

module binomial_tail_probability_tb;
  import btp_pkg::*;

  localparam int MAX_TRIALS      = 32;
  // Drain window: longer than the worst request, so any stray response can show up.
  localparam int DRAIN_CYCLES    = 7 * MAX_TRIALS + 16;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_PHASES   = 16;
  localparam int ITEMS_PER_PHASE = 50;
  // Indexes past the register file; writes to them must change nothing.
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  req_t        req;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  int fail_count;
  int pending;
  int compared_count;
  int issued;
  int settings;
  int cycles;
  bit quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binomial_tail_probability #(
    .MAX_TRIALS(MAX_TRIALS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  btp_tail_checker #(
    .MAX_TRIALS(MAX_TRIALS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req           (req),
    .busy          (busy),
    .done          (done),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .compared_count(compared_count)
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Before raising
  // start, optionally drop it for a random idle burst so the gap lands on
  // different points of the previous request's work.
  task automatic issue(input logic f, input logic [5:0] t);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= req_t'{func: f, threshold: t};
    do @(posedge clk); while (busy);
    issued++;
  endtask

  // Drop start and wait until every response is back and the block is idle.
  // The first edge lets the checker count the request taken at this edge.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  // Hold one register write until the channel takes it; the caller drops valid.
  task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load a new p and n, in random order, once the block has gone quiet.
  task automatic apply_setting(input logic [16:0] p_word, input logic [16:0] n_word);
    wait_idle();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_SUCCESS_PROB, p_word);
      write_reg(CFG_TRIAL_COUNT, n_word);
    end else begin
      write_reg(CFG_TRIAL_COUNT, n_word);
      write_reg(CFG_SUCCESS_PROB, p_word);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [16:0] p_word;
    logic [16:0] n_word;
    int          n_eff;
    logic        f;
    logic [5:0]  t;

    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SUCCESS_PROB;
    cfg_data  <= '0;
    quiet     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values: p = 0, n = 0. Zero to the power zero gives 1.0 at k = 0;
    // any threshold above zero lies beyond the trials.
    issue(FUNC_AT_MOST, 6'd0);
    issue(FUNC_AT_LEAST, 6'd0);
    issue(FUNC_AT_MOST, 6'd63);
    issue(FUNC_AT_LEAST, 6'd1);

    // Certain success over the full trial count.
    apply_setting(ONE_Q16, 17'd32);
    issue(FUNC_AT_MOST, 6'd32);
    issue(FUNC_AT_LEAST, 6'd32);
    issue(FUNC_AT_MOST, 6'd31);
    issue(FUNC_AT_LEAST, 6'd0);

    // Probability above one and trial count above the limit: both clamp.
    apply_setting(17'h1FFFF, 17'h1FFFF);
    issue(FUNC_AT_LEAST, 6'd32);
    issue(FUNC_AT_MOST, 6'd33);
    issue(FUNC_AT_LEAST, 6'd63);

    // Single fair trial.
    apply_setting(17'd32768, 17'd1);
    issue(FUNC_AT_MOST, 6'd0);
    issue(FUNC_AT_LEAST, 6'd1);
    issue(FUNC_AT_LEAST, 6'd2);

    // Smallest and largest p below one over 32 trials.
    apply_setting(17'd1, 17'd32);
    issue(FUNC_AT_LEAST, 6'd1);
    issue(FUNC_AT_MOST, 6'd0);
    apply_setting(17'd65535, 17'd32);
    issue(FUNC_AT_MOST, 6'd31);
    issue(FUNC_AT_LEAST, 6'd16);

    // Writes past the register file must leave p and n alone.
    apply_setting(17'd12345, 17'd20);
    write_reg(CFG_SPARE_LO, 17'($urandom));
    write_reg(CFG_SPARE_HI, 17'($urandom));
    cfg_valid <= 1'b0;
    issue(FUNC_AT_MOST, 6'd10);
    issue(FUNC_AT_LEAST, 6'd10);

    // Random phases: new p and n each time, thresholds mostly within n.
    // Upper data bits of the trial count write are random noise.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0: p_word = '0;
        1: p_word = ONE_Q16;
        2: p_word = 17'($urandom_range(65537, 131071));
        default: p_word = 17'($urandom_range(0, 65536));
      endcase
      n_word = 17'($urandom);
      if ($urandom_range(0, 5) == 0) begin
        n_word[5:0] = 6'($urandom_range(MAX_TRIALS + 1, 63));
      end else begin
        n_word[5:0] = 6'($urandom_range(0, MAX_TRIALS));
      end
      n_eff = (n_word[5:0] > MAX_TRIALS) ? MAX_TRIALS : n_word[5:0];
      // Run the last phase back to back.
      quiet = (ph == RANDOM_PHASES - 1);
      apply_setting(p_word, n_word);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        f = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) begin
          t = 6'($urandom_range(0, 63));
        end else begin
          t = 6'($urandom_range(0, n_eff));
        end
        issue(f, t);
      end
    end

    // Drain, then give any stray response time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d responses checked) over %0d register settings,",
             issued, compared_count, settings);
    $display("  including clamped p and n, thresholds past n and both tail modes.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/btp_pkg.sv
sv/binomial_tail_probability.sv
tb/btp_tail_checker.sv
tb/binomial_tail_probability_tb.sv
